// File: rtl/core/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

    // default sizes for the top level
    localparam int NUM_LISTS_DEF  = 4;
    localparam int LIST_DEPTH_DEF = 16;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MERGE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_FILL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic fill;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic total_zero;
        logic total_one;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/kwm_ram.sv
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kwm_ctrl.sv
`default_nettype none

module kwm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               command,
    input  wire kwm_pkg::dp_status_t status,
    output kwm_pkg::ctrl_cmd_t      cmd
);

    import kwm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (!status.total_zero)
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.total_one ? S_IDLE : S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_PICK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a refill always follows a pick
    a_fill_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> $past(state_reg) == S_PICK)
        else $error("refill without a preceding pick");

    // no transfer is taken while a merge run is in progress
    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.fill) |-> !in_ready)
        else $error("input taken during merge run");
`endif

endmodule

`default_nettype wire

// File: rtl/core/kwm_datapath.sv
`default_nettype none

module kwm_datapath #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kwm_pkg::ctrl_cmd_t                cmd,
    output kwm_pkg::dp_status_t                    status,
    input  wire logic [kwm_pkg::IDX_W-1:0]         list_index,
    input  wire logic signed [kwm_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [kwm_pkg::DATA_W-1:0]      merged_value,
    output logic [kwm_pkg::IDX_W-1:0]              source_list,
    output logic                                   last_flag
);

    import kwm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int TW = $clog2(NUM_LISTS * LIST_DEPTH + 1);
    localparam int LW = $clog2(NUM_LISTS);
    localparam int P  = 1 << LW;
    localparam int NN = 2 * P - 1;

    logic [CW-1:0]            len_reg  [NUM_LISTS];
    logic [CW-1:0]            pos_reg  [NUM_LISTS];
    logic signed [DATA_W-1:0] head_reg [NUM_LISTS];
    logic [DATA_W-1:0]        rd_data  [NUM_LISTS];
    logic [NUM_LISTS-1:0]     lane_wr;
    logic [NUM_LISTS-1:0]     leaf_vld;
    logic [TW-1:0]            total_reg;
    logic [LW-1:0]            sel_reg;
    logic                     clear_all;

    logic signed [DATA_W-1:0] node_val [NN];
    logic [LW-1:0]            node_idx [NN];
    logic                     node_vld [NN];

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] merged_value_reg;
    logic [IDX_W-1:0]         source_list_reg;
    logic                     last_reg;

    // the final emit of a run empties every list
    assign clear_all = cmd.emit && status.total_one;

    // per list: store, length, merge cursor, head value
    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_lane
        logic          hit;
        logic          full;
        logic          lane_emit;
        logic [CW-1:0] pos_inc;
        logic          more;

        assign hit       = cmd.load && (32'(list_index) == g);
        assign full      = (len_reg[g] == CW'(LIST_DEPTH));
        assign lane_wr[g] = hit && !full;
        assign lane_emit = cmd.emit && (node_idx[0] == LW'(g));
        assign pos_inc   = pos_reg[g] + 1'b1;
        assign more      = ({1'b0, pos_inc} < {1'b0, len_reg[g]});
        assign leaf_vld[g] = (pos_reg[g] < len_reg[g]);

        kwm_ram #(
            .WIDTH (DATA_W),
            .DEPTH (LIST_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (lane_wr[g]),
            .wr_addr (len_reg[g][AW-1:0]),
            .wr_data (value),
            .rd_en   (lane_emit && more),
            .rd_addr (pos_inc[AW-1:0]),
            .rd_data (rd_data[g])
        );

        // length and cursor
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                len_reg[g] <= '0;
                pos_reg[g] <= '0;
            end
            else if (clear_all)
            begin
                len_reg[g] <= '0;
                pos_reg[g] <= '0;
            end
            else
            begin
                if (lane_wr[g])
                begin
                    len_reg[g] <= len_reg[g] + 1'b1;
                end
                if (lane_emit)
                begin
                    pos_reg[g] <= pos_inc;
                end
            end
        end

        // head: first load of a list, or refill from its store
        always_ff @(posedge clk)
        begin
            if (lane_wr[g] && (len_reg[g] == '0))
            begin
                head_reg[g] <= value;
            end
            else if (cmd.fill && (sel_reg == LW'(g)))
            begin
                head_reg[g] <= $signed(rd_data[g]);
            end
        end
    end

    // minimum tree over the heads, ties to the lower list
    always_comb
    begin
        logic take_r;
        for (int i = 0; i < P; i++)
        begin
            node_val[P-1+i] = '0;
            node_idx[P-1+i] = LW'(i);
            node_vld[P-1+i] = 1'b0;
        end
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            node_val[P-1+i] = head_reg[i];
            node_vld[P-1+i] = leaf_vld[i];
        end
        for (int n = P - 2; n >= 0; n--)
        begin
            take_r = node_vld[2*n+2] &&
                     (!node_vld[2*n+1] || (node_val[2*n+2] < node_val[2*n+1]));
            node_val[n] = take_r ? node_val[2*n+2] : node_val[2*n+1];
            node_idx[n] = take_r ? node_idx[2*n+2] : node_idx[2*n+1];
            node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
        end
    end

    // stored value count and selected list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            if (clear_all)
            begin
                total_reg <= '0;
            end
            else if (cmd.emit)
            begin
                total_reg <= total_reg - 1'b1;
            end
            else if (|lane_wr)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                sel_reg <= node_idx[0];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            merged_value_reg <= node_val[0];
            source_list_reg  <= IDX_W'(node_idx[0]);
            last_reg         <= status.total_one;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = merged_value_reg;
    assign source_list  = source_list_reg;
    assign last_flag    = last_reg;

    // status to the controller
    assign status.total_zero = (total_reg == '0);
    assign status.total_one  = (total_reg == TW'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    // an emit always finds a non-empty list
    a_emit_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> node_vld[0])
        else $error("emit with no list holding a value");

    // an emit never overwrites a result still waiting
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("emit into a full output register");

    // the last result leaves every list empty
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> (total_reg == '0) && !(|leaf_vld))
        else $error("lists not emptied after final result");
`endif

endmodule

`default_nettype wire

// File: rtl/core/k_way_sorted_merge_core.sv
// k-way sorted merge core
// Input channel (in_valid/in_ready) carries command, list_index and value.
// A load (command 0) appends value to list list_index and gives no
// result. Loads to a full list or to a list index not below NUM_LISTS
// are dropped. Load transfers may arrive every cycle.
// A merge (command 1) emits every stored value in ascending signed order on
// the output channel (out_valid/out_ready) with merged_value, source_list
// and last_flag, ties going to the lower list index; the lists are then
// empty. A merge over empty lists gives no result.
// Sequencing: a merge transfer moves the run to a pick step, which
// selects the minimum head over all lists and loads it into the output
// register once that register is free; a fill step then refills that
// list's head from its own store RAM through the registered read port.
// The input channel is not ready while a merge run is in progress; a load
// is accepted while the last result of a run still waits to be taken.
// A stalled receiver holds the result in the output register and pauses
// the run. Reset empties all lists and the output register; the store RAMs
// need no clearing.
`default_nettype none

module k_way_sorted_merge_core #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [kwm_pkg::IDX_W-1:0]         list_index,
    input  wire logic signed [kwm_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [kwm_pkg::DATA_W-1:0]      merged_value,
    output logic [kwm_pkg::IDX_W-1:0]              source_list,
    output logic                                   last_flag
);

    import kwm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    // list stores, head selection and output register
    kwm_datapath #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .list_index   (list_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .merged_value (merged_value),
        .source_list  (source_list),
        .last_flag    (last_flag)
    );

endmodule

`default_nettype wire
